// File: rtl/at_response_matcher_top_defines.svh
// Assertion macros used by the checker file.
`ifndef AT_RESPONSE_MATCHER_TOP_DEFINES_SVH
`define AT_RESPONSE_MATCHER_TOP_DEFINES_SVH

// Check a property outside reset.
`define ATRM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ATRM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/atrm_pkg.sv
package atrm_pkg;

	localparam int MODE_W      = 2;
	localparam int BYTE_W      = 8;
	localparam int AMOUNT_W    = 32;
	localparam int EVENT_W     = 3;
	localparam int COUNT_OUT_W = 9;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int PAT_REG_W   = 128;
	localparam int LEN_REG_W   = 5;
	localparam int LIMIT_W     = 32;

	localparam int DEF_BUFFER_BYTES = 512;
	localparam int DEF_MAX_PATTERN  = 16;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 32'd1000;

	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;

	// Register indexes (byte address / 8)
	localparam logic [CFG_IDX_W-1:0] REG_SUCC_LO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUCC_HI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUCC_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_HI = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

	// Input mode codes
	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 3'd0,
		EV_SUCCESS = 3'd1,
		EV_FAIL    = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_REJECT  = 3'd4
	} ev_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_BYTE,
		OP_TICK,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [BYTE_W-1:0]   rx_byte;
		logic [AMOUNT_W-1:0] amount;
	} item_t;

	typedef struct packed {
		logic [PAT_REG_W-1:0] succ_pat;
		logic [LEN_REG_W-1:0] succ_len;
		logic [PAT_REG_W-1:0] fail_pat;
		logic [LEN_REG_W-1:0] fail_len;
		logic [LIMIT_W-1:0]   timeout;
	} cfg_t;

endpackage

// File: rtl/atrm_ifs.sv
interface atrm_in_if import atrm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [BYTE_W-1:0]   rx_byte;
	logic [AMOUNT_W-1:0] elapsed_amount;

	modport source (output valid, output mode, output rx_byte, output elapsed_amount,
		input ready);
	modport sink (input valid, input mode, input rx_byte, input elapsed_amount,
		output ready);
endinterface

interface atrm_out_if import atrm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [EVENT_W-1:0]     event_res;
	logic                   busy_flag;
	logic [COUNT_OUT_W-1:0] received_count;

	modport source (output valid, output event_res, output busy_flag, output received_count,
		input ready);
	modport sink (input valid, input event_res, input busy_flag, input received_count,
		output ready);
endinterface

// File: rtl/at_response_matcher_top.sv
// AT command response matcher. Write the success and fail patterns, their lengths and
// the timeout limit over the APB port while the block is idle, then stream words in:
// mode 0 opens an exchange (or is answered with a busy reject), mode 1 delivers a
// received byte, mode 2 adds elapsed time. Every input word yields exactly one result
// word carrying the event code, the busy flag after the word and the stored byte count.
// Throughput is one word per cycle while the receiver keeps up. A result word passes
// through the two-entry input queue, at whose head the combinational window compare of
// both patterns runs, and then sits in the output register until the receiver takes it.
// The queue and the output register absorb short stalls on either side; a long receiver
// stall fills the queue and back-pressures the sender.
// No clearing pass follows reset: the byte window lives in flip-flops that reset clears
// at once.
module at_response_matcher_top import atrm_pkg::*; #(
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
	parameter int MAX_PATTERN  = DEF_MAX_PATTERN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	atrm_in_if.sink               in_ch,
	atrm_out_if.source            out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t  cfg;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// Configuration registers, read back through a plain mux
	atrm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front: accept and classify words, hold them in the queue
	atrm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// Back: exchange state, pattern match, output register
	atrm_back #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAX_PATTERN  (MAX_PATTERN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// File: rtl/atrm_regs.sv
module atrm_regs import atrm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[CFG_ADDR_W-1 -: CFG_IDX_W];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.succ_pat <= '0;
			cfg_q.succ_len <= '0;
			cfg_q.fail_pat <= '0;
			cfg_q.fail_len <= '0;
			cfg_q.timeout  <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_SUCC_LO:  cfg_q.succ_pat[63:0]   <= pwdata;
				REG_SUCC_HI:  cfg_q.succ_pat[127:64] <= pwdata;
				REG_SUCC_LEN: cfg_q.succ_len         <= pwdata[LEN_REG_W-1:0];
				REG_FAIL_LO:  cfg_q.fail_pat[63:0]   <= pwdata;
				REG_FAIL_HI:  cfg_q.fail_pat[127:64] <= pwdata;
				REG_FAIL_LEN: cfg_q.fail_len         <= pwdata[LEN_REG_W-1:0];
				REG_TIMEOUT:  cfg_q.timeout          <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SUCC_LO:  prdata = cfg_q.succ_pat[63:0];
			REG_SUCC_HI:  prdata = cfg_q.succ_pat[127:64];
			REG_SUCC_LEN: prdata = CFG_DATA_W'(cfg_q.succ_len);
			REG_FAIL_LO:  prdata = cfg_q.fail_pat[63:0];
			REG_FAIL_HI:  prdata = cfg_q.fail_pat[127:64];
			REG_FAIL_LEN: prdata = CFG_DATA_W'(cfg_q.fail_len);
			REG_TIMEOUT:  prdata = CFG_DATA_W'(cfg_q.timeout);
			default:      prdata = '0;
		endcase
	end

endmodule

// File: rtl/atrm_front.sv
module atrm_front import atrm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	atrm_in_if.sink in_ch,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;
	item_t            cls;

	// Classify the word by mode
	always_comb begin
		cls.rx_byte = in_ch.rx_byte;
		cls.amount  = in_ch.elapsed_amount;
		case (in_ch.mode)
			MODE_START: cls.op = OP_START;
			MODE_BYTE:  cls.op = OP_BYTE;
			MODE_TICK:  cls.op = OP_TICK;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign in_ch.ready = (32'(cnt_q) != QUEUE_DEPTH);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_item      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/atrm_back.sv
module atrm_back import atrm_pkg::*; #(
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
	parameter int MAX_PATTERN  = DEF_MAX_PATTERN
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	atrm_out_if.source out_ch
);

	localparam int CNT_W = $clog2(BUFFER_BYTES);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int PAT_W = 8 * MAX_PATTERN;

	logic                 busy_q;
	logic                 prefix_q;
	logic [PAT_W-1:0]     win_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LIMIT_W-1:0]   elapsed_q;

	logic                 out_valid_q;
	ev_t                  ev_q;
	logic                 obusy_q;
	logic [COUNT_OUT_W-1:0] ocnt_q;

	logic                 take;
	logic [PAT_W-1:0]     win_byte;
	logic [PAT_W-1:0]     b_top;
	logic [CNT_W-1:0]     cnt_inc;
	logic [LEN_W-1:0]     slen;
	logic [LEN_W-1:0]     flen;
	logic [PAT_W-1:0]     s_pat;
	logic [PAT_W-1:0]     f_pat;
	logic [PAT_W-1:0]     s_align;
	logic [PAT_W-1:0]     f_align;
	logic [MAX_PATTERN-1:0] s_ok;
	logic [MAX_PATTERN-1:0] f_ok;
	logic                 s_match;
	logic                 f_match;
	logic [BYTE_W-1:0]    s_last;
	logic                 s_is_prefix;
	logic                 b_eol;
	logic                 room;
	logic [AMOUNT_W:0]    sum;
	logic [LIMIT_W-1:0]   sum_sat;

	logic                 busy_nx;
	logic                 prefix_nx;
	logic [PAT_W-1:0]     win_nx;
	logic [CNT_W-1:0]     cnt_nx;
	logic [LIMIT_W-1:0]   elapsed_nx;
	ev_t                  ev_nx;
	logic [31:0]          cnt_ext;

	assign take  = q_valid && (!out_valid_q || out_ch.ready);
	assign q_pop = take;

	// Window after shifting in the new byte, newest at the top
	assign b_top    = PAT_W'(q_item.rx_byte) << (PAT_W - 8);
	assign win_byte = (win_q >> 8) | b_top;
	assign cnt_inc  = cnt_q + 1'b1;
	assign room     = (32'(cnt_q) < BUFFER_BYTES - 1);
	assign b_eol    = (q_item.rx_byte == CH_CR) || (q_item.rx_byte == CH_LF);

	// Saturate lengths and align each pattern to the newest end of the window
	always_comb begin
		slen = (32'(cfg.succ_len) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(cfg.succ_len);
		flen = (32'(cfg.fail_len) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(cfg.fail_len);
		s_pat   = cfg.succ_pat[PAT_W-1:0];
		f_pat   = cfg.fail_pat[PAT_W-1:0];
		s_align = s_pat << {(LEN_W'(MAX_PATTERN) - slen), 3'b000};
		f_align = f_pat << {(LEN_W'(MAX_PATTERN) - flen), 3'b000};
		for (int k = 0; k < MAX_PATTERN; k++) begin
			s_ok[k] = ((k + int'(slen)) < MAX_PATTERN) ||
				(win_byte[8*k +: 8] == s_align[8*k +: 8]);
			f_ok[k] = ((k + int'(flen)) < MAX_PATTERN) ||
				(win_byte[8*k +: 8] == f_align[8*k +: 8]);
		end
		s_match = (slen != '0) && (32'(cnt_inc) >= 32'(slen)) && (&s_ok);
		f_match = (flen != '0) && (32'(cnt_inc) >= 32'(flen)) && (&f_ok);
		s_last  = s_align[PAT_W-1 -: 8];
		s_is_prefix = (s_pat[7:0] == CH_PLUS) && (s_last != CH_CR) && (s_last != CH_LF);
	end

	// Saturating elapsed time
	assign sum     = {1'b0, elapsed_q} + {1'b0, q_item.amount};
	assign sum_sat = sum[AMOUNT_W] ? '1 : sum[LIMIT_W-1:0];

	always_comb begin
		busy_nx    = busy_q;
		prefix_nx  = prefix_q;
		win_nx     = win_q;
		cnt_nx     = cnt_q;
		elapsed_nx = elapsed_q;
		ev_nx      = EV_NONE;
		case (q_item.op)
			OP_START: begin
				if (busy_q) begin
					ev_nx = EV_REJECT;
				end else begin
					busy_nx    = 1'b1;
					prefix_nx  = 1'b0;
					win_nx     = '0;
					cnt_nx     = '0;
					elapsed_nx = '0;
				end
			end
			OP_BYTE: begin
				if (busy_q && room) begin
					win_nx     = win_byte;
					cnt_nx     = cnt_inc;
					elapsed_nx = '0;
					if (prefix_q) begin
						if (b_eol) begin
							busy_nx = 1'b0;
							ev_nx   = EV_SUCCESS;
						end
					end else if (s_match) begin
						if (s_is_prefix) begin
							prefix_nx = 1'b1;
						end else begin
							busy_nx = 1'b0;
							ev_nx   = EV_SUCCESS;
						end
					end else if (f_match) begin
						busy_nx = 1'b0;
						ev_nx   = EV_FAIL;
					end
				end
			end
			OP_TICK: begin
				if (busy_q) begin
					if (sum_sat >= cfg.timeout) begin
						busy_nx    = 1'b0;
						elapsed_nx = '0;
						ev_nx      = EV_TIMEOUT;
					end else begin
						elapsed_nx = sum_sat;
					end
				end
			end
			default: ;
		endcase
		cnt_ext = 32'(cnt_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			prefix_q  <= 1'b0;
			win_q     <= '0;
			cnt_q     <= '0;
			elapsed_q <= '0;
		end else if (take) begin
			busy_q    <= busy_nx;
			prefix_q  <= prefix_nx;
			win_q     <= win_nx;
			cnt_q     <= cnt_nx;
			elapsed_q <= elapsed_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_q    <= ev_nx;
			obusy_q <= busy_nx;
			ocnt_q  <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.event_res      = ev_q;
	assign out_ch.busy_flag      = obusy_q;
	assign out_ch.received_count = ocnt_q;

endmodule

// File: rtl/atrm_checker.sv
`include "at_response_matcher_top_defines.svh"

module atrm_checker import atrm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [EVENT_W-1:0]     event_res,
	input logic                   busy_flag,
	input logic [COUNT_OUT_W-1:0] received_count
);

	logic                           stall;
	logic                           end_ev;
	logic [EVENT_W+COUNT_OUT_W:0]   res_word;

	assign stall    = out_valid && !out_ready;
	assign end_ev   = event_res inside {EV_SUCCESS, EV_FAIL, EV_TIMEOUT};
	assign res_word = {event_res, busy_flag, received_count};

	// Drop the result word while reset is held
	`ATRM_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !out_valid, "result valid during reset")

	// Hold a stalled result word
	`ATRM_ASSERT(a_out_hold, stall |=> out_valid && $stable(res_word), "stalled result changed")

	// An ending event leaves the block idle
	`ATRM_ASSERT(a_end_idle, out_valid && end_ev |-> !busy_flag, "ending event while busy")

	// A reject happens only while busy
	`ATRM_ASSERT(a_reject_busy, out_valid && event_res == EV_REJECT |-> busy_flag, "reject while idle")

endmodule

bind at_response_matcher_top atrm_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.event_res      (out_ch.event_res),
	.busy_flag      (out_ch.busy_flag),
	.received_count (out_ch.received_count)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import atrm_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 60;
	localparam int WIN = DEF_MAX_PATTERN;
	localparam int MAX_PRINTS = 40;

	// register settings beyond the random phases
	localparam int SET_DIRECT_A = 8;
	localparam int SET_DIRECT_B = 9;
	localparam int SET_BUFFER = 10;

	typedef struct {
		ev_t                    ev;
		logic                   busy;
		logic [COUNT_OUT_W-1:0] count;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	atrm_in_if  in_ch ();
	atrm_out_if out_ch ();

	at_response_matcher_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	// Shadow copy of the registers and of the matcher state.
	cfg_t              cfg_now;
	logic              m_busy;
	logic [BYTE_W-1:0] m_window [WIN];
	int unsigned       m_stored;
	logic              m_armed;
	logic [LIMIT_W-1:0] m_elapsed;

	item_t    pending_words [$];
	outcome_t expected_results [$];
	item_t    on_wire;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_taken = 0;
	int results_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int ev_seen [5] = '{default: 0};
	int cycles = 0;

	// Output hold-off: the main sequence bumps hold_reqs, the counter below does the rest.
	int hold_left = 0;
	int hold_reqs = 0;
	int hold_seen = 0;

	function automatic int eff_len(logic [LEN_REG_W-1:0] len);
		return (len > WIN) ? WIN : int'(len);
	endfunction

	function automatic logic [BYTE_W-1:0] pat_at(logic [PAT_REG_W-1:0] pat, int i);
		return pat[BYTE_W*i +: BYTE_W];
	endfunction

	function automatic logic [PAT_REG_W-1:0] text_pat(string s);
		logic [PAT_REG_W-1:0] p;
		p = '0;
		for (int i = 0; i < s.len() && i < WIN; i++)
			p[BYTE_W*i +: BYTE_W] = s[i];
		return p;
	endfunction

	// Compare the newest stored bytes against the first len bytes of a pattern.
	function automatic bit window_hit(logic [PAT_REG_W-1:0] pat, int len);
		if (len == 0 || m_stored < len)
			return 1'b0;
		for (int i = 0; i < len; i++)
			if (m_window[WIN-len+i] !== pat_at(pat, i))
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the shadow matcher by one accepted word and return the result it owes.
	function automatic outcome_t predict_word(item_t it);
		outcome_t          r;
		int                slen;
		int                flen;
		logic [BYTE_W-1:0] tail_ch;
		logic [LIMIT_W:0]  sum;
		r.ev = EV_NONE;
		slen = eff_len(cfg_now.succ_len);
		flen = eff_len(cfg_now.fail_len);
		case (it.op)
			OP_START: begin
				if (m_busy) begin
					r.ev = EV_REJECT;
				end else begin
					m_busy = 1'b1;
					m_window = '{default: '0};
					m_stored = 0;
					m_armed = 1'b0;
					m_elapsed = '0;
				end
			end
			OP_BYTE: begin
				// drop bytes once the buffer is full: no match, no elapsed clear
				if (m_busy && m_stored < DEF_BUFFER_BYTES - 1) begin
					for (int i = 0; i < WIN - 1; i++)
						m_window[i] = m_window[i+1];
					m_window[WIN-1] = it.rx_byte;
					m_stored++;
					m_elapsed = '0;
					if (m_armed) begin
						if (it.rx_byte == CH_CR || it.rx_byte == CH_LF) begin
							m_busy = 1'b0;
							r.ev = EV_SUCCESS;
						end
					end else if (window_hit(cfg_now.succ_pat, slen)) begin
						tail_ch = pat_at(cfg_now.succ_pat, slen - 1);
						if (tail_ch == CH_CR || tail_ch == CH_LF ||
								pat_at(cfg_now.succ_pat, 0) != CH_PLUS) begin
							m_busy = 1'b0;
							r.ev = EV_SUCCESS;
						end else begin
							// line prefix: wait for the end of the line
							m_armed = 1'b1;
						end
					end else if (window_hit(cfg_now.fail_pat, flen)) begin
						m_busy = 1'b0;
						r.ev = EV_FAIL;
					end
				end
			end
			OP_TICK: begin
				if (m_busy) begin
					sum = {1'b0, m_elapsed} + {1'b0, it.amount};
					m_elapsed = sum[LIMIT_W] ? '1 : sum[LIMIT_W-1:0];
					if (m_elapsed >= cfg_now.timeout) begin
						m_busy = 1'b0;
						m_elapsed = '0;
						r.ev = EV_TIMEOUT;
					end
				end
			end
			default: ;
		endcase
		r.busy = m_busy;
		r.count = m_stored[COUNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		if (mismatches < MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void push_word(op_t op, logic [BYTE_W-1:0] b, logic [AMOUNT_W-1:0] a);
		item_t it;
		it.op = op;
		it.rx_byte = b;
		it.amount = a;
		pending_words.push_back(it);
	endfunction

	// Queue the first len bytes of a pattern as received bytes; return how many.
	function automatic int push_pattern(logic [PAT_REG_W-1:0] pat, int len);
		for (int i = 0; i < len; i++)
			push_word(OP_BYTE, pat_at(pat, i), $urandom);
		return len;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] len_word(int len);
		logic [CFG_DATA_W-1:0] w;
		// junk in the upper bits must be ignored
		w = {$urandom, $urandom};
		w[LEN_REG_W-1:0] = len[LEN_REG_W-1:0];
		return w;
	endfunction

	// APB write: setup cycle, then access cycle; the register takes the value at its end.
	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SUCC_LO:  cfg_now.succ_pat[63:0] = val;
			REG_SUCC_HI:  cfg_now.succ_pat[127:64] = val;
			REG_SUCC_LEN: cfg_now.succ_len = val[LEN_REG_W-1:0];
			REG_FAIL_LO:  cfg_now.fail_pat[63:0] = val;
			REG_FAIL_HI:  cfg_now.fail_pat[127:64] = val;
			REG_FAIL_LEN: cfg_now.fail_len = val[LEN_REG_W-1:0];
			REG_TIMEOUT:  cfg_now.timeout = val[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// Program one full register setting; every register is written each time.
	task automatic apply_setting(int k);
		logic [PAT_REG_W-1:0] sp;
		logic [PAT_REG_W-1:0] fp;
		int                   sn;
		int                   fn;
		logic [LIMIT_W-1:0]   lim;
		string                alpha;
		alpha = "AB\r+";
		sp = {$urandom, $urandom, $urandom, $urandom};
		fp = {$urandom, $urandom, $urandom, $urandom};
		sn = 0;
		fn = 0;
		lim = TIMEOUT_RESET;
		case (k)
			0: begin
				sp = text_pat("OK\r\n");
				sn = 4;
				fp = text_pat("ERROR\r\n");
				fn = 7;
			end
			1: begin
				sp = text_pat("+CREG:");
				sn = 6;
				fp = text_pat("ERROR");
				fn = 5;
				lim = '0;
			end
			2: begin
				// full-length patterns over a tiny alphabet so that partial overlaps occur
				for (int i = 0; i < WIN; i++) begin
					sp[BYTE_W*i +: BYTE_W] = alpha[$urandom_range(3)];
					fp[BYTE_W*i +: BYTE_W] = alpha[$urandom_range(3)];
				end
				sn = WIN;
				fn = WIN;
				lim = '1;
			end
			3: begin
				sn = 31;
				fn = 0;
				lim = $urandom_range(1, 2000);
			end
			4: begin
				sn = 0;
				fn = 1;
				lim = 300;
			end
			5: begin
				sp = text_pat("+");
				sn = 1;
				fp = text_pat("\r\n");
				fn = 2;
			end
			6: begin
				// zero bytes in the pattern match the cleared window only once enough is stored
				sp = '0;
				sn = 3;
				fn = $urandom_range(17, 31);
				lim = 800;
			end
			7: begin
				sn = $urandom_range(0, 31);
				fn = $urandom_range(0, 31);
				lim = $urandom_range(0, 1500);
			end
			SET_DIRECT_A: begin
				sp = text_pat("OK\r\n");
				sn = 4;
				fp = text_pat("ER");
				fn = 2;
				lim = 50;
			end
			SET_DIRECT_B: begin
				sp = text_pat("+Q");
				sn = 2;
				fp = text_pat("ER");
				fn = 2;
				lim = '0;
			end
			default: ;
		endcase
		reg_write(REG_SUCC_LO, sp[63:0]);
		reg_write(REG_SUCC_HI, sp[127:64]);
		reg_write(REG_SUCC_LEN, len_word(sn));
		reg_write(REG_FAIL_LO, fp[63:0]);
		reg_write(REG_FAIL_HI, fp[127:64]);
		reg_write(REG_FAIL_LEN, len_word(fn));
		reg_write(REG_TIMEOUT, {$urandom, lim});
		settings_used++;
	endtask

	// Mostly well-formed exchanges with random content, plus noise and broken patterns.
	task automatic fill_random(int budget);
		int made;
		int n;
		int pick;
		int slen;
		int flen;
		made = 0;
		slen = eff_len(cfg_now.succ_len);
		flen = eff_len(cfg_now.fail_len);
		while (made < budget) begin
			if ($urandom_range(9) == 0) begin
				push_word(op_t'($urandom_range(3)), 8'($urandom), $urandom);
				made++;
			end else begin
				push_word(OP_START, 8'($urandom), $urandom);
				made++;
				n = $urandom_range(1, 10);
				for (int j = 0; j < n; j++) begin
					pick = $urandom_range(99);
					if (pick < 18) begin
						made += push_pattern(cfg_now.succ_pat, slen);
					end else if (pick < 26) begin
						made += push_pattern(cfg_now.succ_pat, $urandom_range(0, slen));
					end else if (pick < 40) begin
						made += push_pattern(cfg_now.fail_pat, flen);
					end else if (pick < 45) begin
						made += push_pattern(cfg_now.fail_pat, $urandom_range(0, flen));
					end else if (pick < 52) begin
						push_word(OP_BYTE, $urandom_range(1) ? CH_CR : CH_LF, $urandom);
						made++;
					end else if (pick < 56) begin
						push_word(OP_BYTE, CH_PLUS, $urandom);
						made++;
					end else if (pick < 68) begin
						push_word(OP_TICK, 8'($urandom), $urandom_range(0, 700));
						made++;
					end else if (pick < 71) begin
						push_word(OP_TICK, 8'($urandom), $urandom);
						made++;
					end else if (pick < 74) begin
						push_word(OP_START, 8'($urandom), $urandom);
						made++;
					end else begin
						push_word(OP_BYTE, 8'($urandom), $urandom);
						made++;
					end
				end
				// close the exchange by a saturating tick now and then
				if ($urandom_range(1) == 1) begin
					push_word(OP_TICK, 8'($urandom), '1);
					made++;
				end
			end
		end
	endtask

	// Hold until every queued word is taken and every expected result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sender: offer the next queued word when the channel is free, idling at random.
	always @(posedge clk) begin
		item_t nxt;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(predict_word(on_wire));
				words_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_words.pop_front();
					on_wire = nxt;
					in_ch.valid <= 1'b1;
					in_ch.mode <= nxt.op;
					in_ch.rx_byte <= nxt.rx_byte;
					in_ch.elapsed_amount <= nxt.amount;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result word against the oldest expectation, stall at random.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result word with no expectation pending");
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					ev_seen[int'(want.ev)]++;
					if (out_ch.event_res !== want.ev)
						flag_mismatch($sformatf("word %0d: event_res %0d, expected %0d",
							results_checked, out_ch.event_res, want.ev));
					if (out_ch.busy_flag !== want.busy)
						flag_mismatch($sformatf("word %0d: busy_flag %0b, expected %0b",
							results_checked, out_ch.busy_flag, want.busy));
					if (out_ch.received_count !== want.count)
						flag_mismatch($sformatf("word %0d: received_count %0d, expected %0d",
							results_checked, out_ch.received_count, want.count));
				end
			end
			out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off so the input queue fills and back-pressures the sender.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding",
				expected_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		// drive every input to a known value from time zero
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_START;
		in_ch.rx_byte = '0;
		in_ch.elapsed_amount = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		cfg_now = '0;
		cfg_now.timeout = TIMEOUT_RESET;
		m_busy = 1'b0;
		m_window = '{default: '0};
		m_stored = 0;
		m_armed = 1'b0;
		m_elapsed = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Directed: idle items, reject while busy, full success line, fail, timeout.
		apply_setting(SET_DIRECT_A);
		push_word(OP_NOP, 8'hFF, '1);
		push_word(OP_BYTE, "O", '0);
		push_word(OP_TICK, 8'h00, 77);
		push_word(OP_START, 8'h00, '0);
		push_word(OP_START, 8'hFF, '1);
		void'(push_pattern(text_pat("OK\r\n"), 4));
		push_word(OP_START, 8'h5A, '0);
		void'(push_pattern(text_pat("ER"), 2));
		push_word(OP_START, 8'hA5, '1);
		push_word(OP_BYTE, 8'h00, '1);
		push_word(OP_BYTE, 8'hFF, '0);
		push_word(OP_TICK, 8'hFF, 30);
		push_word(OP_TICK, 8'h00, 30);
		wait_drained();

		// Directed: line prefix arms, fail is ignored, LF completes; zero limit times out.
		apply_setting(SET_DIRECT_B);
		push_word(OP_START, 8'h00, '0);
		void'(push_pattern(text_pat("+Q"), 2));
		void'(push_pattern(text_pat("ER"), 2));
		push_word(OP_BYTE, CH_LF, '0);
		push_word(OP_START, 8'h00, '0);
		push_word(OP_TICK, 8'h00, '0);
		wait_drained();

		// Fill the byte buffer; dropped bytes must not clear the elapsed time.
		apply_setting(SET_BUFFER);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		push_word(OP_START, 8'($urandom), $urandom);
		repeat (DEF_BUFFER_BYTES + 8) push_word(OP_BYTE, 8'($urandom), $urandom);
		push_word(OP_TICK, 8'($urandom), 600);
		push_word(OP_BYTE, 8'($urandom), $urandom);
		push_word(OP_TICK, 8'($urandom), 600);
		wait_drained();

		// Random phases, each with its own setting and one of four idling mixes.
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			apply_setting(k);
			case (k % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			fill_random(WORDS_PER_PHASE);
			if (k == 0)
				hold_reqs++;
			wait_drained();
		end

		$display("Covered %0d input words over %0d register settings, with idling on both sides",
			words_taken, settings_used);
		$display("Events: %0d success, %0d fail, %0d timeout, %0d busy reject, %0d none",
			ev_seen[EV_SUCCESS], ev_seen[EV_FAIL], ev_seen[EV_TIMEOUT], ev_seen[EV_REJECT],
			ev_seen[EV_NONE]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/atrm_pkg.sv
rtl/atrm_ifs.sv
rtl/atrm_regs.sv
rtl/atrm_front.sv
rtl/atrm_back.sv
rtl/at_response_matcher_top.sv
rtl/atrm_checker.sv
bench/testbench.sv
